/* sv/ami_pkg.sv */
// Package for the affine matrix inverse block: widths, codes and shared types.
// Used by ami_front, ami_fifo, ami_back and affine_matrix_inverse; depends on nothing.
package ami_pkg;

  localparam int WordBits  = 32;
  localparam int FracBits  = 16;
  localparam int ElemCount = 12;
  localparam int CntBits   = 4;
  localparam int ProdBits  = 2 * WordBits + 1;
  localparam int CofBits   = 2 * WordBits + 2;
  localparam int TrBits    = 3 * WordBits + 5;
  localparam int NumBits   = TrBits + 2 * FracBits;
  localparam int QBits     = NumBits;
  localparam int QIdxBits  = $clog2(QBits + 1);
  localparam int FifoDepth = 2;
  localparam int LoBits    = WordBits + 1;
  localparam int MulABits  = WordBits + 2;
  localparam int MulBits   = MulABits + WordBits;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  singular;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COF,
    BK_TR,
    BK_DIV,
    BK_EMIT
  } back_state_e;

endpackage

/* sv/ami_front.sv */
// Front part: collects twelve elements per matrix and hands a full matrix to the back.
// Depends on ami_pkg.
module ami_front import ami_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  word_t elem_value_i,
  output logic  mat_valid_o,
  input  logic  mat_ready_i,
  output word_t mat_o [ElemCount]
);

  cnt_t  count_q, count_d;
  logic  held_q, held_d;
  word_t store_q [ElemCount];

  assign full        = held_q;
  assign mat_valid_o = held_q;
  assign mat_o       = store_q;

  always_comb begin
    count_d = count_q;
    held_d  = held_q;
    if (held_q && mat_ready_i) begin
      held_d = 1'b0;
    end
    if (push && !held_q) begin
      if (count_q == cnt_t'(ElemCount - 1)) begin
        count_d = '0;
        held_d  = 1'b1;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      held_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !held_q) begin
      store_q[count_q] <= elem_value_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q < cnt_t'(ElemCount))
    else $error("element count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q |-> count_q == '0)
    else $error("count not cleared while matrix held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !held_q && count_q == cnt_t'(ElemCount - 1)) |=> held_q)
    else $error("full matrix not handed on");

endmodule

/* sv/ami_fifo.sv */
// Small result queue between the back part and the output ports.
// Depends on ami_pkg.
module ami_fifo import ami_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wdata_i,
  output logic    full_o,
  output logic    empty_o,
  input  logic    rd_i,
  output result_t rdata_o
);

  localparam int PtrBits = $clog2(FifoDepth);

  result_t mem_q [FifoDepth];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [PtrBits:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o  = cnt_q == (PtrBits + 1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + PtrBits'(1);
      if (do_rd) rp_q <= rp_q + PtrBits'(1);
      cnt_q <= cnt_q + (PtrBits + 1)'(do_wr) - (PtrBits + 1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

endmodule

/* sv/ami_back.sv */
// Back part: cofactors, translation terms and determinant on one shared multiplier,
// then a radix-2 restoring divider per element. Depends on ami_pkg.
module ami_back import ami_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mat_valid_i,
  output logic    mat_ready_o,
  input  word_t   mat_i [ElemCount],
  output logic    res_valid_o,
  input  logic    res_full_i,
  output result_t res_o
);

  typedef logic signed [TrBits-1:0] tr_t;
  typedef logic [NumBits-1:0] num_t;

  back_state_e state_q, state_d;
  word_t e_q [ElemCount];
  tr_t   c_q [ElemCount];
  tr_t   det_q;
  logic [4:0] step_q;
  cnt_t  k_q;
  num_t  n_q, q_q;
  logic [NumBits:0] r_q;
  num_t  d_q;
  logic  neg_q;
  logic [QIdxBits-1:0] bit_q;

  // Shared multiplier operand selection.
  logic signed [MulABits-1:0] ma;
  word_t mb;
  logic signed [MulBits-1:0] prod;
  logic signed [CofBits-1:0] pa_q;
  logic phase_q;
  tr_t  tsel, term;

  function automatic logic [3:0] cof_idx(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      4'd0: r = 4'd0; 4'd1: r = 4'd4; 4'd2: r = 4'd8;
      4'd3: r = 4'd1; 4'd4: r = 4'd5; 4'd5: r = 4'd9;
      4'd6: r = 4'd2; 4'd7: r = 4'd6; default: r = 4'd10;
    endcase
    return r;
  endfunction

  // A cofactor is split into an unsigned low part and a signed high part, one per cycle.
  always_comb begin
    ma = '0;
    mb = '0;
    tsel = (step_q[1:0] == 2'd3) ? c_q[{step_q[3:2], 2'd0}] : c_q[{step_q[3:2], step_q[1:0]}];
    case (state_q)
      BK_COF: begin
        case (step_q[3:0])
          4'd0: begin ma = MulABits'(phase_q ? e_q[9] : e_q[5]);
                      mb = phase_q ? e_q[6] : e_q[10]; end
          4'd1: begin ma = MulABits'(phase_q ? e_q[4] : e_q[8]);
                      mb = phase_q ? e_q[10] : e_q[6]; end
          4'd2: begin ma = MulABits'(phase_q ? e_q[8] : e_q[4]);
                      mb = phase_q ? e_q[5] : e_q[9]; end
          4'd3: begin ma = MulABits'(phase_q ? e_q[1] : e_q[9]);
                      mb = phase_q ? e_q[10] : e_q[2]; end
          4'd4: begin ma = MulABits'(phase_q ? e_q[8] : e_q[0]);
                      mb = phase_q ? e_q[2] : e_q[10]; end
          4'd5: begin ma = MulABits'(phase_q ? e_q[0] : e_q[8]);
                      mb = phase_q ? e_q[9] : e_q[1]; end
          4'd6: begin ma = MulABits'(phase_q ? e_q[5] : e_q[1]);
                      mb = phase_q ? e_q[2] : e_q[6]; end
          4'd7: begin ma = MulABits'(phase_q ? e_q[0] : e_q[4]);
                      mb = phase_q ? e_q[6] : e_q[2]; end
          default: begin ma = MulABits'(phase_q ? e_q[4] : e_q[0]);
                      mb = phase_q ? e_q[1] : e_q[5]; end
        endcase
      end
      BK_TR: begin
        ma = phase_q ? {{2{tsel[2*WordBits]}}, tsel[2*WordBits:LoBits]}
                     : {1'b0, tsel[LoBits-1:0]};
        mb = (step_q[1:0] == 2'd3) ? e_q[{2'd0, step_q[3:2]}]
                                   : e_q[{step_q[1:0], 2'd3}];
      end
      default: ;
    endcase
  end

  assign prod = MulBits'(ma) * MulBits'(mb);
  assign term = phase_q ? (TrBits'(prod) <<< LoBits) : TrBits'(prod);

  num_t num_abs, det_abs;
  tr_t  ck;
  logic [NumBits:0] r_sh, r_sub;
  logic [WordBits-1:0] sat_val;
  logic over;
  localparam logic [WordBits-1:0] MaxPos = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinNeg = {1'b1, {(WordBits-1){1'b0}}};

  always_comb begin
    ck = c_q[k_q];
    if (k_q[1:0] == 2'd3) num_abs = NumBits'(ck) <<< FracBits;
    else                  num_abs = NumBits'(ck) <<< (2 * FracBits);
    if (ck[TrBits-1]) num_abs = -num_abs;
    det_abs = det_q[TrBits-1] ? NumBits'(-det_q) : NumBits'(det_q);
    r_sh  = {r_q[NumBits-1:0], n_q[bit_q]};
    r_sub = r_sh - {1'b0, d_q};
    over  = |q_q[NumBits-1:WordBits];
    if (!neg_q) sat_val = (over || q_q[WordBits-1]) ? MaxPos : q_q[WordBits-1:0];
    else if (over || q_q[WordBits-1:0] > MinNeg) sat_val = MinNeg;
    else sat_val = -q_q[WordBits-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (mat_valid_i) state_d = BK_COF;
      BK_COF:  if (phase_q && step_q == 5'd8) state_d = BK_TR;
      BK_TR:   if (phase_q && step_q == 5'd11) state_d = BK_DIV;
      BK_DIV:  if (det_q == '0 || bit_q == '0) state_d = BK_EMIT;
      BK_EMIT: if (!res_full_i) begin
        if (det_q == '0 || k_q == cnt_t'(ElemCount - 1)) state_d = BK_IDLE;
        else state_d = BK_DIV;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    mat_ready_o = state_q == BK_IDLE;
    res_valid_o = state_q == BK_EMIT;
    res_o.singular = det_q == '0;
    res_o.last  = det_q == '0 || k_q == cnt_t'(ElemCount - 1);
    res_o.value = det_q == '0 ? '0 : sat_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
      phase_q <= 1'b0;
      k_q     <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_IDLE: begin step_q <= '0; phase_q <= 1'b0; k_q <= '0; end
        BK_COF: begin
          phase_q <= !phase_q;
          if (phase_q) step_q <= (step_q == 5'd8) ? 5'd0 : step_q + 5'd1;
        end
        BK_TR: begin
          phase_q <= !phase_q;
          if (phase_q) step_q <= step_q + 5'd1;
          if (phase_q && step_q == 5'd11) bit_q <= QIdxBits'(NumBits);
        end
        BK_DIV: if (bit_q != '0) bit_q <= bit_q - QIdxBits'(1);
        BK_EMIT: if (!res_full_i) begin
          k_q   <= k_q + cnt_t'(1);
          bit_q <= QIdxBits'(NumBits);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        e_q   <= mat_i;
        det_q <= '0;
      end
      BK_COF: begin
        if (!phase_q) pa_q <= CofBits'(prod);
        else c_q[cof_idx(step_q[3:0])] <= TrBits'(pa_q) - TrBits'(prod);
      end
      BK_TR: begin
        if (step_q[1:0] == 2'd3) det_q <= det_q + term;
        else if (step_q[1:0] == 2'd0 && !phase_q) c_q[{step_q[3:2], 2'd3}] <= -term;
        else c_q[{step_q[3:2], 2'd3}] <= c_q[{step_q[3:2], 2'd3}] - term;
      end
      BK_DIV: begin
        if (bit_q == QIdxBits'(NumBits)) begin
          n_q   <= num_abs;
          d_q   <= det_abs;
          neg_q <= ck[TrBits-1] ^ det_q[TrBits-1];
          r_q   <= '0;
          q_q   <= '0;
        end else begin
          if (!r_sub[NumBits]) begin
            r_q <= r_sub;
            q_q[bit_q] <= 1'b1;
          end else r_q <= r_sh;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/affine_matrix_inverse.sv */
// Top level of the affine 3x4 matrix inverse by the adjugate.
// Depends on ami_pkg, ami_front, ami_back and ami_fifo.
//
// Input: a queue port. An element is taken when push is high and full is low;
// twelve elements, row-major, signed Q16.16, make one matrix.
// Output: a queue port. While empty is low the oldest result is on out_value_o,
// out_last_o and singular_o; pop takes it.
// Twelve results per matrix, the last marked, or one singular result when the
// determinant is zero.
// The back takes the matrix from the front while idle, then forms the cofactor
// products and the translation and determinant terms on the shared
// multiplier. Each element then takes a load step, the quotient bits one per
// cycle, and a write to the result queue. A singular matrix skips the division
// and writes its single result.
// The front holds a finished matrix while the back works, so loading of the
// next matrix overlaps the division of the current one.
// A stalled receiver fills the two-entry result queue and then holds the back.
// Reset clears the element count and all control state.
module affine_matrix_inverse import ami_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  word_t elem_value_i,
  output logic  empty,
  input  logic  pop,
  output word_t out_value_o,
  output logic  out_last_o,
  output logic  singular_o
);

  word_t   mat [ElemCount];
  logic    mat_valid, mat_ready, res_valid, res_full;
  result_t res, head;

  ami_front u_front (
    .clk_i, .rst_ni, .push, .full, .elem_value_i,
    .mat_valid_o(mat_valid), .mat_ready_i(mat_ready), .mat_o(mat)
  );

  ami_back u_back (
    .clk_i, .rst_ni, .mat_valid_i(mat_valid), .mat_ready_o(mat_ready), .mat_i(mat),
    .res_valid_o(res_valid), .res_full_i(res_full), .res_o(res)
  );

  ami_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(res_valid), .wdata_i(res), .full_o(res_full),
    .empty_o(empty), .rd_i(pop), .rdata_o(head)
  );

  assign out_value_o = head.value;
  assign out_last_o  = head.last;
  assign singular_o  = head.singular;

endmodule

/* verif/affine_matrix_inverse_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for affine_matrix_inverse: loads 3x4 affine matrices and checks
// every inverse element, last mark and singular flag against an exact adjugate predictor.
// Depends on ami_pkg and the affine_matrix_inverse RTL.
module affine_matrix_inverse_test;
  import ami_pkg::*;

  localparam int Wide = 256;
  localparam int CycleLimit = 3000000;
  localparam int RandMatrices = 25;

  typedef logic signed [Wide-1:0] wide_t;

  typedef struct {
    word_t value;
    logic  last;
    logic  singular;
  } inverse_elem_t;

  typedef struct {
    word_t elem;
    logic  checked;
    word_t value;
    logic  last;
    logic  singular;
  } table_row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  push = 1'b0;
  logic  full;
  word_t elem_value_i = '0;
  logic  empty;
  logic  pop = 1'b0;
  word_t out_value_o;
  logic  out_last_o;
  logic  singular_o;

  inverse_elem_t inverse_queue[$];
  inverse_elem_t typed_queue[$];
  logic          typed_valid[$];
  word_t         matrix_elems[ElemCount];
  int            elem_count = 0;
  int            failures = 0;
  int            cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          hold_pop = 1'b0;
  logic          sending_done = 1'b0;
  table_row_t    directed[$];

  affine_matrix_inverse i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .elem_value_i(elem_value_i), .empty(empty), .pop(pop),
    .out_value_o(out_value_o), .out_last_o(out_last_o), .singular_o(singular_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic word_t div_saturate(wide_t num, wide_t den);
    wide_t quo;
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (WordBits - 1)) - 1;
    lo = -(wide_t'(1) <<< (WordBits - 1));
    quo = num / den;
    if (quo > hi) return word_t'(hi);
    if (quo < lo) return word_t'(lo);
    return word_t'(quo);
  endfunction

  task automatic predict_inverse();
    wide_t m[ElemCount];
    wide_t cof[ElemCount];
    wide_t det;
    wide_t num;
    inverse_elem_t res;
    for (int k = 0; k < ElemCount; k++) m[k] = wide_t'(matrix_elems[k]);
    cof[0]  = m[5] * m[10] - m[9] * m[6];
    cof[4]  = m[8] * m[6] - m[4] * m[10];
    cof[8]  = m[4] * m[9] - m[8] * m[5];
    cof[1]  = m[9] * m[2] - m[1] * m[10];
    cof[5]  = m[0] * m[10] - m[8] * m[2];
    cof[9]  = m[8] * m[1] - m[0] * m[9];
    cof[2]  = m[1] * m[6] - m[5] * m[2];
    cof[6]  = m[4] * m[2] - m[0] * m[6];
    cof[10] = m[0] * m[5] - m[4] * m[1];
    for (int r = 0; r < 3; r++) begin
      cof[r*4+3] = -(cof[r*4] * m[3] + cof[r*4+1] * m[7] + cof[r*4+2] * m[11]);
    end
    det = m[0] * cof[0] + m[1] * cof[4] + m[2] * cof[8];
    if (det == 0) begin
      res = '{value: '0, last: 1'b1, singular: 1'b1};
      inverse_queue.push_back(res);
    end else begin
      for (int k = 0; k < ElemCount; k++) begin
        num = ((k % 4) == 3) ? (cof[k] <<< FracBits) : (cof[k] <<< (2 * FracBits));
        res.value = div_saturate(num, det);
        res.last = (k == ElemCount - 1);
        res.singular = 1'b0;
        inverse_queue.push_back(res);
      end
    end
  endtask

  task automatic push_elem(word_t value, logic checked, inverse_elem_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    elem_value_i <= value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    matrix_elems[elem_count] = value;
    elem_count++;
    if (elem_count == ElemCount) begin
      elem_count = 0;
      predict_inverse();
    end
    if (checked) begin
      typed_queue.push_back(typed);
      typed_valid.push_back(1'b1);
    end
  endtask

  task automatic push_matrix(word_t m[ElemCount]);
    inverse_elem_t none;
    none = '{value: '0, last: 1'b0, singular: 1'b0};
    for (int k = 0; k < ElemCount; k++) push_elem(m[k], 1'b0, none);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (inverse_queue.size() != 0) @(negedge clk_i);
  endtask

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(131072)) - word_t'(65536);
      2: return word_t'($urandom_range(2000)) - word_t'(1000);
      default: return word_t'(0);
    endcase
  endfunction

  // Directed table: singular rows carry their typed expectation on the twelfth element.
  task automatic build_directed();
    word_t maxw;
    word_t minw;
    maxw = {1'b0, {(WordBits-1){1'b1}}};
    minw = {1'b1, {(WordBits-1){1'b0}}};
    for (int k = 0; k < ElemCount; k++) begin
      directed.push_back('{elem: '0, checked: (k == ElemCount - 1),
                           value: '0, last: 1'b1, singular: 1'b1});
    end
    for (int k = 0; k < ElemCount; k++) begin
      directed.push_back('{elem: (k % 5 == 0) ? maxw : (k % 4 == 3 ? minw : word_t'(0)),
                           checked: 1'b0, value: '0, last: 1'b0, singular: 1'b0});
    end
  endtask

  initial begin
    word_t m[ElemCount];
    inverse_elem_t typed;
    int mode;
    build_directed();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      typed = '{value: directed[i].value, last: directed[i].last,
                singular: directed[i].singular};
      push_elem(directed[i].elem, directed[i].checked, typed);
    end
    for (int n = 0; n < RandMatrices; n++) begin
      case (n % 9)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        3: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        5: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        7: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: ;
      endcase
      if (n == 4) hold_pop <= 1'b1;
      if (n == 10) wait_drained();
      mode = $urandom_range(3);
      for (int k = 0; k < ElemCount; k++) begin
        m[k] = (mode == 3) ? rand_word($urandom_range(2)) : rand_word(mode);
        if (mode == 3 && k % 4 != 3 && $urandom_range(1)) m[k] = word_t'(0);
      end
      if (n % 6 == 5) for (int k = 0; k < 4; k++) m[8+k] = m[k];
      push_matrix(m);
    end
    push <= 1'b0;
    sending_done <= 1'b1;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_pop) begin
        repeat (4000) @(posedge clk_i);
        hold_pop <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= !hold_pop && rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    inverse_elem_t exp;
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) begin
      if (inverse_queue.size() == 0) begin
        $error("result with none expected: value %0d", out_value_o);
        failures++;
      end else begin
        exp = inverse_queue.pop_front();
        if (exp.singular && typed_queue.size() != 0) begin
          exp = typed_queue.pop_front();
          void'(typed_valid.pop_front());
        end
        if (out_value_o !== exp.value) begin
          $error("out_value expected %0d actual %0d", exp.value, out_value_o);
          failures++;
        end
        if (out_last_o !== exp.last) begin
          $error("out_last expected %0b actual %0b", exp.last, out_last_o);
          failures++;
        end
        if (singular_o !== exp.singular) begin
          $error("singular expected %0b actual %0b", exp.singular, singular_o);
          failures++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (inverse_queue.size() != 0 && cycles < CycleLimit) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
    if (inverse_queue.size() == 0 && failures == 0) begin
      $display("PASS affine_matrix_inverse");
    end else begin
      $display("FAIL affine_matrix_inverse");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("FAIL affine_matrix_inverse");
    $finish;
  end

endmodule
